// ===== hw/rtl/pmt_pkg.sv =====
`timescale 1ns / 1ps

package pmt_pkg;

    // Fixed field widths
    localparam int PRESCALE_W  = 16;
    localparam int VALUE_W     = 32;
    localparam int MAX_CH      = 4;
    localparam int CTL_BITS    = 3;
    localparam int CTL_W       = MAX_CH * CTL_BITS;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Per-channel control bit positions
    localparam int CTL_IRQ  = 0;
    localparam int CTL_RST  = 1;
    localparam int CTL_STOP = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_VALUE_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_VALUE_1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_VALUE_2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_VALUE_3  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_CONTROL  = 3'd5;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_START = 2'd2,
        MODE_STOP  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [MAX_CH-1:0] set_flags;
        logic              stop;
    } match_res_t;

endpackage

// ===== hw/rtl/pmt_if.sv =====
`timescale 1ns / 1ps

interface pmt_cmd_if;
    logic          valid;
    logic          ready;
    pmt_pkg::mode_t mode;
    logic [3:0]    clear_mask;

    modport source (output valid, output mode, output clear_mask, input ready);
    modport sink   (input valid, input mode, input clear_mask, output ready);
endinterface

interface pmt_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] counter_value;
    logic [3:0]  match_flags;
    logic        interrupt_request;
    logic        running;

    modport source (output valid, output counter_value, output match_flags,
                    output interrupt_request, output running, input ready);
    modport sink   (input valid, input counter_value, input match_flags,
                    input interrupt_request, input running, output ready);
endinterface

// ===== hw/rtl/pmt_match.sv =====
`timescale 1ns / 1ps

module pmt_match #(
    parameter int CHANNELS      = 4,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic [COUNTER_WIDTH-1:0]      count,
    input  logic [pmt_pkg::VALUE_W-1:0]   match_value [CHANNELS],
    input  logic [pmt_pkg::CTL_W-1:0]     match_control,
    output logic [COUNTER_WIDTH-1:0]      count_next,
    output pmt_pkg::match_res_t           res
);
    import pmt_pkg::*;

    logic [CHANNELS-1:0] rst_hit;
    logic [CHANNELS-1:0] new_hit;
    logic [CHANNELS-1:0] stop_hit;
    logic [CHANNELS-1:0] irq_hit;

    // Reset-on-match looks at the current count, flag and stop at the new one
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            rst_hit[ch] = match_control[ch*CTL_BITS + CTL_RST]
                          && (VALUE_W'(count) == match_value[ch]);
        end
        count_next = (|rst_hit) ? '0 : count + COUNTER_WIDTH'(1);
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            new_hit[ch]  = VALUE_W'(count_next) == match_value[ch];
            irq_hit[ch]  = new_hit[ch] && match_control[ch*CTL_BITS + CTL_IRQ];
            stop_hit[ch] = new_hit[ch] && match_control[ch*CTL_BITS + CTL_STOP];
        end
        res.set_flags = MAX_CH'(irq_hit);
        res.stop      = |stop_hit;
    end

endmodule

// ===== hw/rtl/prescaled_match_timer_core.sv =====
`timescale 1ns / 1ps

// Prescaled match timer: a counter advanced once per (prescale_limit + 1)
// running ticks, with CHANNELS compare channels that can set a flag, reload
// the counter to zero and stop the timer. Each command item (tick, clear
// flags, reset-and-start, stop) yields one result item showing the counter,
// the flags, the interrupt request and the running bit after that command.
// The block takes one item per clock: the command updates the timer state
// and the result register in the cycle it is accepted, and the result is
// presented from the next cycle on. The result register is the only thing
// that can hold the command side back: cmd.ready is high whenever that
// register is empty or is being taken in the same cycle.
// Configuration writes land at once; write only while no result is pending.

module prescaled_match_timer_core #(
    parameter int CHANNELS      = 4,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    pmt_cmd_if.sink                           cmd,
    pmt_res_if.source                         res,
    input  logic                              cfg_we,
    input  logic [pmt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pmt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import pmt_pkg::*;

    // Configuration registers
    logic [PRESCALE_W-1:0] prescale_limit_reg;
    logic [VALUE_W-1:0]    match_value_reg [CHANNELS];
    logic [CTL_W-1:0]      match_control_reg;

    // Timer state
    logic [PRESCALE_W-1:0]    prescale_count_reg, prescale_count_next;
    logic [COUNTER_WIDTH-1:0] timer_count_reg, timer_count_next;
    logic [MAX_CH-1:0]        flags_reg, flags_next;
    logic                     enabled_reg, enabled_next;

    // Result register
    logic                     res_valid_reg;
    logic [VALUE_W-1:0]       res_count_reg;
    logic [MAX_CH-1:0]        res_flags_reg;
    logic                     res_running_reg;

    logic [COUNTER_WIDTH-1:0] count_adv;
    match_res_t               match_res;
    logic                     accept;
    logic                     advance;
    logic [MAX_CH-1:0]        ch_mask;

    // Register decode: match values by channel, the rest by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_limit_reg <= '0;
            match_control_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                REG_PRESCALE_LIMIT: prescale_limit_reg <= cfg_wdata[PRESCALE_W-1:0];
                REG_MATCH_CONTROL:  match_control_reg  <= cfg_wdata[CTL_W-1:0];
                REG_MATCH_VALUE_0, REG_MATCH_VALUE_1,
                REG_MATCH_VALUE_2, REG_MATCH_VALUE_3: ;  // handled per channel
                default: ;                               // drop unknown indexes
            endcase
        end
    end

    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_match_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                match_value_reg[ch] <= '0;
            else if (cfg_we && cfg_index == REG_MATCH_VALUE_0 + CFG_IDX_W'(ch))
                match_value_reg[ch] <= cfg_wdata[VALUE_W-1:0];
        end
    end

    // Compare channels and counter step
    pmt_match #(
        .CHANNELS      (CHANNELS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_match (
        .count         (timer_count_reg),
        .match_value   (match_value_reg),
        .match_control (match_control_reg),
        .count_next    (count_adv),
        .res           (match_res)
    );

    // Hold cmd back only while a result waits and is not being taken
    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign ch_mask = MAX_CH'((1 << CHANNELS) - 1);
    assign advance = enabled_reg && (prescale_count_reg == prescale_limit_reg);

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        timer_count_next    = timer_count_reg;
        flags_next          = flags_reg;
        enabled_next        = enabled_reg;
        case (cmd.mode)
            MODE_TICK:
            begin
                if (advance)
                begin
                    // Roll the prescaler over and step the counter
                    prescale_count_next = '0;
                    timer_count_next    = count_adv;
                    flags_next          = (flags_reg | match_res.set_flags) & ch_mask;
                    if (match_res.stop)
                        enabled_next = 1'b0;
                end
                else if (enabled_reg)
                    prescale_count_next = prescale_count_reg + PRESCALE_W'(1);
            end
            MODE_CLEAR:
                flags_next = flags_reg & ~cmd.clear_mask;
            MODE_START:
            begin
                // Keep the prescale count
                timer_count_next = '0;
                flags_next       = '0;
                enabled_next     = 1'b1;
            end
            default:
                enabled_next = 1'b0;
        endcase
    end

    // Advance state on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            timer_count_reg    <= '0;
            flags_reg          <= '0;
            enabled_reg        <= 1'b0;
        end
        else if (accept)
        begin
            prescale_count_reg <= prescale_count_next;
            timer_count_reg    <= timer_count_next;
            flags_reg          <= flags_next;
            enabled_reg        <= enabled_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_count_reg   <= VALUE_W'(timer_count_next);
            res_flags_reg   <= flags_next;
            res_running_reg <= enabled_next;
        end
    end

    assign res.valid             = res_valid_reg;
    assign res.counter_value     = res_count_reg;
    assign res.match_flags       = res_flags_reg;
    assign res.interrupt_request = |res_flags_reg;
    assign res.running           = res_running_reg;

endmodule

// ===== hw/rtl/pmt_checker.sv =====
`timescale 1ns / 1ps

module pmt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic [1:0]  cmd_mode,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_counter_value,
    input logic [3:0]  res_match_flags,
    input logic        res_interrupt_request,
    input logic        res_running
);
    import pmt_pkg::*;

    // An empty result register never holds the command side back
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> cmd_ready)
        else $error("cmd not ready with empty result register");

    a_irq_follows_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_interrupt_request == (res_match_flags != 4'd0)))
        else $error("interrupt request disagrees with flags");

    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd_mode == MODE_START) |=>
        (res_valid && res_counter_value == 32'd0 && res_match_flags == 4'd0
         && res_running))
        else $error("reset-and-start result wrong");

    a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd_mode == MODE_STOP) |=>
        (res_valid && !res_running))
        else $error("stop result still running");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_counter_value)))
        else $error("stalled result changed");

endmodule

bind prescaled_match_timer_core pmt_checker u_pmt_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd_valid             (cmd.valid),
    .cmd_ready             (cmd.ready),
    .cmd_mode              (cmd.mode),
    .res_valid             (res.valid),
    .res_ready             (res.ready),
    .res_counter_value     (res.counter_value),
    .res_match_flags       (res.match_flags),
    .res_interrupt_request (res.interrupt_request),
    .res_running           (res.running)
);

// ===== tb/sv/tb_prescaled_match_timer_core.sv =====
`timescale 1ns / 1ps

module tb_prescaled_match_timer_core;

    import pmt_pkg::*;

    // Per-channel control patterns, built from the package bit positions
    localparam logic [2:0] ON_NONE = 3'b000;
    localparam logic [2:0] ON_IRQ  = 3'(1 << CTL_IRQ);
    localparam logic [2:0] ON_RST  = 3'(1 << CTL_RST);
    localparam logic [2:0] ON_STOP = 3'(1 << CTL_STOP);

    // One timer snapshot as the result channel presents it
    typedef struct packed {
        logic [31:0] counter_value;
        logic [3:0]  match_flags;
        logic        interrupt_request;
        logic        running;
    } timer_view_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    pmt_cmd_if cmd_ch ();
    pmt_res_if res_ch ();

    prescaled_match_timer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of the timer: register copies and running state
    logic [15:0] pre_limit;
    logic [31:0] match_val [4];
    logic [11:0] match_ctl;
    logic [15:0] pre_count;
    logic [31:0] tmr_count;
    logic [3:0]  pend_flags;
    logic        tmr_running;

    timer_view_t expected_views [$];

    int tx_idle_pct;
    int rx_idle_pct;
    bit rx_hold;

    int num_sent;
    int num_checked;
    int num_fail;
    int num_settings;

    // Apply one command to the shadow timer and return the snapshot the block
    // should show afterwards.
    function automatic timer_view_t apply_command(mode_t m, logic [3:0] mask);
        logic       hit_reset;
        logic [2:0] ctl;
        hit_reset = 1'b0;
        case (m)
            MODE_TICK:
            begin
                if (tmr_running)
                begin
                    if (pre_count == pre_limit)
                    begin
                        pre_count = '0;
                        // Reset-on-match looks at the value before the advance
                        for (int ch = 0; ch < 4; ch++)
                        begin
                            ctl = match_ctl[3*ch +: 3];
                            if (ctl[CTL_RST] && tmr_count == match_val[ch])
                                hit_reset = 1'b1;
                        end
                        tmr_count = hit_reset ? 32'd0 : tmr_count + 32'd1;
                        // Flags and stops follow the new value
                        for (int ch = 0; ch < 4; ch++)
                        begin
                            ctl = match_ctl[3*ch +: 3];
                            if (tmr_count == match_val[ch])
                            begin
                                if (ctl[CTL_IRQ])
                                    pend_flags[ch] = 1'b1;
                                if (ctl[CTL_STOP])
                                    tmr_running = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        pre_count = pre_count + 16'd1;
                    end
                end
            end
            MODE_CLEAR:
                pend_flags = pend_flags & ~mask;
            MODE_START:
            begin
                // Prescale count is deliberately kept
                tmr_count   = '0;
                pend_flags  = '0;
                tmr_running = 1'b1;
            end
            default:
                tmr_running = 1'b0;
        endcase
        return '{tmr_count, pend_flags, |pend_flags, tmr_running};
    endfunction

    // Offer one command item, holding it until the block takes it, then
    // queue the snapshot it should produce. Valid is left high on return so
    // that back-to-back items need no second assignment in the same step.
    task automatic send_cmd(input mode_t m, input logic [3:0] mask);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_ch.valid      <= 1'b0;
            cmd_ch.mode       <= mode_t'($urandom_range(0, 3));
            cmd_ch.clear_mask <= 4'($urandom_range(0, 15));
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.mode       <= m;
        cmd_ch.clear_mask <= mask;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        expected_views.push_back(apply_command(m, mask));
        num_sent++;
    endtask

    // Drop valid and wait until every queued snapshot has come back, plus a
    // little slack.
    task automatic wait_idle;
        cmd_ch.valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_PRESCALE_LIMIT: pre_limit    = data[15:0];
            REG_MATCH_VALUE_0:  match_val[0] = data;
            REG_MATCH_VALUE_1:  match_val[1] = data;
            REG_MATCH_VALUE_2:  match_val[2] = data;
            REG_MATCH_VALUE_3:  match_val[3] = data;
            REG_MATCH_CONTROL:  match_ctl    = data[11:0];
            default: ;
        endcase
    endtask

    // Write the whole register set; only call while the block is idle
    task automatic set_config(input logic [15:0] lim, input logic [31:0] v0,
                              input logic [31:0] v1, input logic [31:0] v2,
                              input logic [31:0] v3, input logic [11:0] ctl);
        write_reg(REG_PRESCALE_LIMIT, 32'(lim));
        write_reg(REG_MATCH_VALUE_0, v0);
        write_reg(REG_MATCH_VALUE_1, v1);
        write_reg(REG_MATCH_VALUE_2, v2);
        write_reg(REG_MATCH_VALUE_3, v3);
        write_reg(REG_MATCH_CONTROL, 32'(ctl));
        cfg_we <= 1'b0;
        num_settings++;
    endtask

    // Bias towards short prescales and small match values so that matches
    // actually happen, with the odd full-range or extreme setting mixed in.
    task automatic random_settings;
        logic [31:0] mv [4];
        logic [15:0] lim;
        logic [11:0] ctl;
        int          r;
        r = $urandom_range(0, 9);
        if (r < 6)
            lim = 16'($urandom_range(0, 3));
        else if (r < 8)
            lim = 16'($urandom_range(0, 65535));
        else if (r == 8)
            lim = 16'hffff;
        else
            lim = 16'h0;
        for (int i = 0; i < 4; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 8)
                mv[i] = 32'($urandom_range(0, 24));
            else if (r == 8)
                mv[i] = $urandom;
            else
                mv[i] = 32'hffff_ffff;
        end
        r = $urandom_range(0, 9);
        if (r < 8)
            ctl = 12'($urandom_range(0, 4095));
        else if (r == 8)
            ctl = 12'hfff;
        else
            ctl = 12'h0;
        set_config(lim, mv[0], mv[1], mv[2], mv[3], ctl);
    endtask

    // Commands on a stopped timer: ticks do nothing, stray masks are ignored
    task automatic test_stopped_commands;
        set_config(16'h0, 32'd0, 32'd0, 32'd0, 32'd0, 12'h0);
        send_cmd(MODE_TICK, 4'h0);
        send_cmd(MODE_CLEAR, 4'hf);
        send_cmd(MODE_STOP, 4'ha);
        send_cmd(MODE_TICK, 4'h5);
        wait_idle();
    endtask

    // Several channels hitting the same value at once, stop on match, a tick
    // while stopped, partial flag clears and reset-on-match back to zero
    task automatic test_match_channels;
        set_config(16'd1, 32'd3, 32'd3, 32'd0, 32'd3,
                   {ON_STOP, ON_IRQ, ON_IRQ, ON_IRQ | ON_RST});
        send_cmd(MODE_START, 4'h0);
        repeat (6) send_cmd(MODE_TICK, 4'h0);
        send_cmd(MODE_TICK, 4'hf);
        send_cmd(MODE_CLEAR, 4'b0001);
        wait_idle();

        set_config(16'd0, 32'd3, 32'd3, 32'd0, 32'd3,
                   {ON_NONE, ON_IRQ, ON_IRQ, ON_IRQ | ON_RST});
        send_cmd(MODE_START, 4'hf);
        repeat (5) send_cmd(MODE_TICK, 4'h0);
        send_cmd(MODE_CLEAR, 4'hf);
        send_cmd(MODE_STOP, 4'h0);
        wait_idle();
    endtask

    // Prescale count left above a lowered limit keeps counting and must not
    // roll over; then the largest limit. Unreachable all-ones match values
    // with every control bit set must never fire.
    task automatic test_prescale_extremes;
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        set_config(16'd20, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                   32'hffff_ffff, 12'hfff);
        send_cmd(MODE_START, 4'h0);
        repeat (15) send_cmd(MODE_TICK, 4'h0);
        wait_idle();
        set_config(16'd4, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                   32'hffff_ffff, 12'hfff);
        repeat (30) send_cmd(MODE_TICK, 4'h0);
        wait_idle();
        set_config(16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                   32'hffff_ffff, 12'hfff);
        repeat (40) send_cmd(MODE_TICK, 4'h0);
        wait_idle();
    endtask

    // Hold the result side off for a long stretch while commands keep
    // coming, so the result register fills and the command side stalls.
    task automatic test_backpressure;
        set_config(16'd0, 32'd7, 32'd12, 32'd20, 32'd25,
                   {ON_IRQ, ON_IRQ | ON_RST, ON_IRQ, ON_STOP});
        fork
            begin
                rx_hold <= 1'b1;
                repeat (40) @(posedge clk);
                rx_hold <= 1'b0;
            end
            begin
                send_cmd(MODE_START, 4'h0);
                repeat (30) send_cmd(MODE_TICK, 4'h0);
            end
        join
        wait_idle();
    endtask

    // Random traffic in segments, each under a fresh register setting.
    // Mostly a start followed by ticks, with clears, restarts and stops mixed
    // in; every mask is random so ignored masks are covered too.
    task automatic test_random_traffic;
        int    seg_count [3] = '{5, 5, 4};
        int    r;
        mode_t m;
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    tx_idle_pct = 22;
                    rx_idle_pct <= 64;
                end
                1:
                begin
                    tx_idle_pct = 64;
                    rx_idle_pct <= 22;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            for (int s = 0; s < seg_count[p]; s++)
            begin
                random_settings();
                if ($urandom_range(0, 9) != 0)
                    send_cmd(MODE_START, 4'($urandom_range(0, 15)));
                repeat (90)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 72)
                        m = MODE_TICK;
                    else if (r < 82)
                        m = MODE_CLEAR;
                    else if (r < 90)
                        m = MODE_START;
                    else
                        m = MODE_STOP;
                    send_cmd(m, 4'($urandom_range(0, 15)));
                end
                wait_idle();
            end
        end
    endtask

    // Result side: check each accepted item against the oldest snapshot and
    // choose ready for the next cycle.
    always @(posedge clk)
    begin
        timer_view_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_views.size() == 0)
            begin
                if (num_fail < 10)
                    $display("%0t: result item with nothing outstanding: counter %h flags %b",
                             $realtime, res_ch.counter_value, res_ch.match_flags);
                num_fail++;
            end
            else
            begin
                want = expected_views.pop_front();
                num_checked++;
                if (res_ch.counter_value !== want.counter_value
                    || res_ch.match_flags !== want.match_flags
                    || res_ch.interrupt_request !== want.interrupt_request
                    || res_ch.running !== want.running)
                begin
                    if (num_fail < 10)
                        $display({"%0t: mismatch, want cnt %h flg %b irq %b run %b,",
                                  " got cnt %h flg %b irq %b run %b"},
                                 $realtime, want.counter_value, want.match_flags,
                                 want.interrupt_request, want.running,
                                 res_ch.counter_value, res_ch.match_flags,
                                 res_ch.interrupt_request, res_ch.running);
                    num_fail++;
                end
            end
        end
        res_ch.ready <= rst_n && !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial
    begin
        // Drive every input to a known value and clear the shadow state
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.mode       = MODE_TICK;
        cmd_ch.clear_mask = '0;
        res_ch.ready      = 1'b0;
        rx_hold           = 1'b0;
        tx_idle_pct       = 0;
        rx_idle_pct       = 0;
        pre_limit         = '0;
        match_ctl         = '0;
        for (int i = 0; i < 4; i++)
            match_val[i] = '0;
        pre_count         = '0;
        tmr_count         = '0;
        pend_flags        = '0;
        tmr_running       = 1'b0;
        num_sent          = 0;
        num_checked       = 0;
        num_fail          = 0;
        num_settings      = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles lightly, receiver heavily, for the first directed tests
        tx_idle_pct = 22;
        rx_idle_pct <= 64;
        test_stopped_commands();
        test_match_channels();
        test_prescale_extremes();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (4) @(posedge clk);

        $display("Ran %0d command items under %0d register settings; %0d results checked.",
                 num_sent, num_settings, num_checked);
        $display("Covered stopped ticks, coincident matches, prescale above limit and stalls.");
        if (num_fail == 0 && expected_views.size() == 0)
            $display("tb_prescaled_match_timer_core OK");
        else
            $display("tb_prescaled_match_timer_core NOT OK");
        $finish;
    end

    // Watchdog: the slowest correct run is well under a fifth of this
    initial
    begin
        #6_000_000;
        $display("tb_prescaled_match_timer_core NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pmt_pkg.sv
hw/rtl/pmt_if.sv
hw/rtl/pmt_match.sv
hw/rtl/prescaled_match_timer_core.sv
hw/rtl/pmt_checker.sv
tb/sv/tb_prescaled_match_timer_core.sv
